[hdl/mts_pkg.sv]
// Package for the melody tone sequencer: widths, command codes, reset values,
// controller state and divider operand enums, and the controller/datapath structs.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package mts_pkg;

   localparam int NOTE_DEPTH_DEFAULT = 64;

   localparam int CLOCK_HZ_W = 27;
   localparam int TEMPO_W    = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 27;

   localparam int REQ_USER_W = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   localparam int FREQ_W     = 13;
   localparam int CODE_W     = 8;
   localparam int SLOT_W     = 6;
   localparam int MLEN_W     = 7;
   localparam int POS_W      = 6;

   localparam int DIV_NUM_W  = 27;
   localparam int DIV_DEN_W  = 13;
   localparam int WHOLE_W    = 18;
   localparam int NOTE_MS_W  = 19;
   localparam int KHZ_W      = 18;
   localparam int PROD_W     = KHZ_W + NOTE_MS_W;
   localparam int TICKS_W    = 32;

   localparam int MS_PER_MIN = 60000;
   localparam int MS_PER_S   = 1000;

   localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET = CLOCK_HZ_W'(80000000);
   localparam logic [TEMPO_W-1:0]    TEMPO_RESET    = TEMPO_W'(200);

   localparam logic [REQ_USER_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [REQ_USER_W-1:0] CMD_START = 2'd1;
   localparam logic [REQ_USER_W-1:0] CMD_TICK  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_HZ  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_BPM = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MUL,
      ST_FIN
   } ctrl_state_type;

   typedef enum logic [1:0] {
      DSEL_PERIOD,
      DSEL_TEMPO,
      DSEL_MAG
   } div_sel_type;

   typedef struct packed {
      logic        accept;
      logic        mem_read;
      logic        div_start;
      logic        div_capture;
      div_sel_type div_sel;
      logic        mul_load;
      logic        ticks_load;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic begin_req;
      logic div_done;
   } dp_stat_type;

endpackage

[hdl/mts_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on mts_pkg for the operand widths.
`timescale 1ns / 1ps

module mts_div import mts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic [DIV_NUM_W-1:0] quotient,
   output logic                 done
);

   localparam int CNT_W = $clog2(DIV_NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_shift;
   logic [DIV_DEN_W:0]   rem_diff;

   assign rem_shift = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_diff[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

[hdl/mts_datapath.sv]
// Datapath of the melody tone sequencer: note store, playback state, tone and
// duration arithmetic and the result register. Depends on mts_pkg and mts_div.
`timescale 1ns / 1ps

module mts_datapath import mts_pkg::*; #(
   parameter int NOTE_DEPTH = NOTE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic [CLOCK_HZ_W-1:0] clock_hz,
   input  logic [TEMPO_W-1:0]    tempo_bpm,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int IDX_W      = $clog2(NOTE_DEPTH);
   localparam int LEN_W      = (IDX_W + 1 > MLEN_W) ? IDX_W + 1 : MLEN_W;
   localparam int SLOT_EXT_W = IDX_W + SLOT_W;
   localparam int POS_EXT_W  = IDX_W + POS_W;

   // Division of the sampled clock by 1000: drop three bits, then multiply by
   // the rounded-up reciprocal of 125 and keep bits 31 and up. This is exact
   // for every 24-bit operand.
   localparam int KHZ_PRE_SHIFT  = 3;
   localparam int KHZ_RECIP_W    = 25;
   localparam int KHZ_POST_SHIFT = 31;
   localparam int KHZ_OPND_W     = CLOCK_HZ_W - KHZ_PRE_SHIFT;
   localparam int KHZ_PROD_W     = KHZ_OPND_W + KHZ_RECIP_W;
   localparam logic [KHZ_RECIP_W-1:0] KHZ_RECIP = KHZ_RECIP_W'(17179870);

   // Note store: frequency and signed length code per entry.
   logic [FREQ_W-1:0] freq_mem [NOTE_DEPTH];
   logic [CODE_W-1:0] code_mem [NOTE_DEPTH];

   logic [FREQ_W-1:0]        rd_freq_ff;
   logic signed [CODE_W-1:0] rd_code_ff;

   logic                  active_ff, active_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [LEN_W-1:0]      mlen_ff, mlen_in;
   logic [CLOCK_HZ_W-1:0] period_ff, period_in;
   logic [CLOCK_HZ_W-1:0] phase_ff, phase_in;
   logic [TICKS_W-1:0]    ticks_ff, ticks_in;

   logic [CLOCK_HZ_W-1:0] clk_snap_ff, clk_snap_in;
   logic [TEMPO_W-1:0]    tempo_snap_ff, tempo_snap_in;
   logic [WHOLE_W-1:0]    whole_ff, whole_in;
   logic [NOTE_MS_W-1:0]  note_ms_ff, note_ms_in;
   logic [KHZ_W-1:0]      khz_ff, khz_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_level_ff, rsp_level_in;
   logic                  rsp_playing_ff, rsp_playing_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic                  rsp_done_ff, rsp_done_in;

   // Request fields.
   logic [REQ_USER_W-1:0]    f_cmd;
   logic [SLOT_W-1:0]        f_slot;
   logic [FREQ_W-1:0]        f_freq;
   logic [CODE_W-1:0]        f_code;
   logic [MLEN_W-1:0]        f_mlen;

   logic [SLOT_EXT_W-1:0]    slot_ext;
   logic                     slot_ok;
   logic [LEN_W-1:0]         mlen_ext;
   logic [LEN_W-1:0]         mlen_sat;
   logic [LEN_W-1:0]         next_note;
   logic                     more_notes;
   logic                     note_ends;
   logic                     tone_high;
   logic [CLOCK_HZ_W:0]      phase_inc;
   logic [CLOCK_HZ_W-1:0]    phase_next;
   logic [POS_EXT_W-1:0]     pos_ext;
   logic [POS_W-1:0]         cur_pos;

   logic                     div_start;
   logic [DIV_NUM_W-1:0]     div_dividend;
   logic [DIV_DEN_W-1:0]     div_divisor;
   logic [DIV_NUM_W-1:0]     div_quotient;
   logic                     div_done;
   logic [CODE_W-1:0]        code_mag;
   logic [CODE_W-1:0]        code_mag_fix;
   logic [TEMPO_W-1:0]       tempo_fix;
   logic [WHOLE_W-1:0]       q_note;
   logic [NOTE_MS_W:0]       q_triple;
   logic [TICKS_W-1:0]       ticks_sat;
   logic [KHZ_OPND_W-1:0]    clk_eighth;
   logic [KHZ_PROD_W-1:0]    khz_prod;

   assign f_cmd  = req_tuser;
   assign f_slot = req_tdata[5:0];
   assign f_freq = req_tdata[18:6];
   assign f_code = req_tdata[26:19];
   assign f_mlen = req_tdata[33:27];

   assign slot_ext = SLOT_EXT_W'(f_slot);
   assign slot_ok  = slot_ext < SLOT_EXT_W'(NOTE_DEPTH);
   assign mlen_ext = LEN_W'(f_mlen);
   assign mlen_sat = (mlen_ext > LEN_W'(NOTE_DEPTH)) ? LEN_W'(NOTE_DEPTH) : mlen_ext;

   assign next_note  = LEN_W'(cur_ff) + LEN_W'(1);
   assign more_notes = next_note < mlen_ff;
   assign note_ends  = active_ff && (ticks_ff == TICKS_W'(1));

   assign tone_high  = (period_ff >= CLOCK_HZ_W'(2)) && (phase_ff < (period_ff >> 1));
   assign phase_inc  = {1'b0, phase_ff} + (CLOCK_HZ_W + 1)'(1);
   assign phase_next = (phase_inc >= {1'b0, period_ff}) ? '0 : phase_inc[CLOCK_HZ_W-1:0];

   assign pos_ext = POS_EXT_W'(cur_ff);
   assign cur_pos = pos_ext[POS_W-1:0];

   assign stat.out_free  = !rsp_valid_ff || rsp_tready;
   assign stat.begin_req = ((f_cmd == CMD_START) && (f_mlen != '0)) ||
                           ((f_cmd == CMD_TICK) && note_ends && more_notes);
   assign stat.div_done  = div_done;

   // Divider operands, picked by the sequencer step.
   assign code_mag     = rd_code_ff[CODE_W-1] ? (~rd_code_ff + CODE_W'(1)) : rd_code_ff;
   assign code_mag_fix = (code_mag == '0) ? CODE_W'(1) : code_mag;
   assign tempo_fix    = (tempo_snap_ff == '0) ? TEMPO_W'(1) : tempo_snap_ff;
   assign div_start    = cmd.div_start;

   assign clk_eighth = clk_snap_ff[CLOCK_HZ_W-1:KHZ_PRE_SHIFT];
   assign khz_prod   = KHZ_PROD_W'(clk_eighth) * KHZ_PROD_W'(KHZ_RECIP);

   always_comb begin
      unique case (cmd.div_sel)
         DSEL_PERIOD: begin
            div_dividend = clk_snap_ff;
            div_divisor  = rd_freq_ff;
         end
         DSEL_TEMPO: begin
            div_dividend = DIV_NUM_W'(MS_PER_MIN);
            div_divisor  = DIV_DEN_W'(tempo_fix);
         end
         DSEL_MAG: begin
            div_dividend = DIV_NUM_W'(whole_ff);
            div_divisor  = DIV_DEN_W'(code_mag_fix);
         end
         default: begin
            div_dividend = clk_snap_ff;
            div_divisor  = rd_freq_ff;
         end
      endcase
   end

   mts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // A dotted note lasts one and a half times the plain length.
   assign q_note   = div_quotient[WHOLE_W-1:0];
   assign q_triple = (NOTE_MS_W + 1)'(q_note) + (NOTE_MS_W + 1)'({q_note, 1'b0});
   assign ticks_sat = (prod_ff[PROD_W-1:TICKS_W] != '0) ? '1 :
                      (prod_ff[TICKS_W-1:0] == '0) ? TICKS_W'(1) : prod_ff[TICKS_W-1:0];

   always_comb begin
      active_in      = active_ff;
      cur_in         = cur_ff;
      mlen_in        = mlen_ff;
      period_in      = period_ff;
      phase_in       = phase_ff;
      ticks_in       = ticks_ff;
      clk_snap_in    = clk_snap_ff;
      tempo_snap_in  = tempo_snap_ff;
      whole_in       = whole_ff;
      note_ms_in     = note_ms_ff;
      khz_in         = khz_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_level_in   = rsp_level_ff;
      rsp_playing_in = rsp_playing_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_done_in    = rsp_done_ff;

      if (cmd.accept) begin
         clk_snap_in    = clock_hz;
         tempo_snap_in  = tempo_bpm;
         rsp_valid_in   = 1'b1;
         rsp_level_in   = 1'b0;
         rsp_done_in    = 1'b0;
         rsp_playing_in = active_ff;
         rsp_pos_in     = cur_pos;
         unique case (f_cmd)
            CMD_TICK: begin
               if (active_ff) begin
                  rsp_level_in = tone_high;
                  phase_in     = phase_next;
                  ticks_in     = ticks_ff - TICKS_W'(1);
                  if (note_ends) begin
                     if (more_notes) begin
                        cur_in   = next_note[IDX_W-1:0];
                        phase_in = '0;
                     end else begin
                        active_in   = 1'b0;
                        rsp_done_in = 1'b1;
                     end
                  end
               end
            end
            CMD_START: begin
               mlen_in    = mlen_sat;
               cur_in     = '0;
               phase_in   = '0;
               rsp_pos_in = '0;
               if (f_mlen == '0) begin
                  active_in      = 1'b0;
                  rsp_playing_in = 1'b0;
               end else begin
                  active_in      = 1'b1;
                  rsp_playing_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.mem_read) begin
         khz_in = khz_prod[KHZ_POST_SHIFT +: KHZ_W];
      end

      if (cmd.div_capture) begin
         unique case (cmd.div_sel)
            DSEL_PERIOD: period_in  = (rd_freq_ff == '0) ? '0 : div_quotient;
            DSEL_TEMPO:  whole_in   = {div_quotient[WHOLE_W-3:0], 2'b00};
            DSEL_MAG:    note_ms_in = rd_code_ff[CODE_W-1] ? q_triple[NOTE_MS_W:1]
                                                           : NOTE_MS_W'(q_note);
            default:     period_in  = period_ff;
         endcase
      end

      if (cmd.mul_load) begin
         prod_in = PROD_W'(khz_ff) * PROD_W'(note_ms_ff);
      end

      if (cmd.ticks_load) begin
         ticks_in = ticks_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cur_ff       <= '0;
         mlen_ff      <= '0;
         period_ff    <= '0;
         phase_ff     <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cur_ff       <= cur_in;
         mlen_ff      <= mlen_in;
         period_ff    <= period_in;
         phase_ff     <= phase_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clk_snap_ff    <= clk_snap_in;
      tempo_snap_ff  <= tempo_snap_in;
      whole_ff       <= whole_in;
      note_ms_ff     <= note_ms_in;
      khz_ff         <= khz_in;
      prod_ff        <= prod_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_playing_ff <= rsp_playing_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_done_ff    <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && (f_cmd == CMD_LOAD) && slot_ok) begin
         freq_mem[slot_ext[IDX_W-1:0]] <= f_freq;
         code_mem[slot_ext[IDX_W-1:0]] <= f_code;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_freq_ff <= freq_mem[cur_ff];
         rd_code_ff <= code_mem[cur_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pos_ff, rsp_playing_ff, rsp_level_ff};
   assign rsp_tlast  = rsp_done_ff;

endmodule

[hdl/mts_ctrl.sv]
// Controller of the melody tone sequencer: accepts words and steps the datapath
// through the note setup sequence. Depends on mts_pkg.
`timescale 1ns / 1ps

module mts_ctrl import mts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   div_sel_type    sel_ff, sel_in;
   logic           accept;

   assign req_tready = (state_ff == ST_IDLE) && stat.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && stat.begin_req) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            sel_in   = DSEL_PERIOD;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               unique case (sel_ff)
                  DSEL_PERIOD: begin
                     sel_in   = DSEL_TEMPO;
                     state_in = ST_DIV_GO;
                  end
                  DSEL_TEMPO: begin
                     sel_in   = DSEL_MAG;
                     state_in = ST_DIV_GO;
                  end
                  DSEL_MAG: begin
                     state_in = ST_MUL;
                  end
                  default: begin
                     state_in = ST_MUL;
                  end
               endcase
            end
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.accept      = accept;
      cmd.div_sel     = sel_ff;
      unique case (state_ff)
         ST_IDLE:     cmd.accept      = accept;
         ST_READ:     cmd.mem_read    = 1'b1;
         ST_DIV_GO:   cmd.div_start   = 1'b1;
         ST_DIV_WAIT: cmd.div_capture = stat.div_done;
         ST_MUL:      cmd.mul_load    = 1'b1;
         ST_FIN:      cmd.ticks_load  = 1'b1;
         default:     cmd.accept      = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= DSEL_PERIOD;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

[hdl/melody_tone_sequencer_core.sv]
// Melody tone sequencer top level: configuration registers, controller and datapath.
// Depends on mts_pkg, mts_ctrl and mts_datapath (which holds mts_div).
`timescale 1ns / 1ps

// Usage:
// Request words carry a command in req_tuser: load a note into the store, start
// a melody, or advance playback by one tick. Every word gives exactly one
// response word on the rsp_ channel: square-wave level, playing flag and the
// note position, with rsp_tlast high on the tick that ends the last note.
// The response is registered and appears the cycle after the request is taken.
// Loads, idle ticks and ticks inside a note are taken one word per cycle while the
// response side keeps up. A non-empty start word, and a tick that ends a note with
// another one to follow, set up the next note: the request side then stalls
// while the shared bit-serial divider runs three 27-bit divisions, with a store
// read before them and one multiply and a saturation step after.
// clock_hz and tempo_bpm are written through the csr_ port and take effect for
// notes set up after the write. Reset stops playback and returns the registers
// to 80 MHz and 200 bpm; the note store is not cleared.
// A stalled response holds its word; the block takes a new request only when
// the response register is empty or being drained in the same cycle.
module melody_tone_sequencer_core import mts_pkg::*; #(
   parameter int NOTE_DEPTH = NOTE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata: write_slot, note_freq, note_len_code, melody_length
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: command
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: buzzer_level, playing, note_position
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CLOCK_HZ_W-1:0] clock_hz_ff, clock_hz_in;
   logic [TEMPO_W-1:0]    tempo_bpm_ff, tempo_bpm_in;
   dp_cmd_type            cmd;
   dp_stat_type           stat;

   always_comb begin
      clock_hz_in  = clock_hz_ff;
      tempo_bpm_in = tempo_bpm_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CLOCK_HZ:  clock_hz_in  = csr_wdata[CLOCK_HZ_W-1:0];
            CSR_TEMPO_BPM: tempo_bpm_in = csr_wdata[TEMPO_W-1:0];
            default:       clock_hz_in  = clock_hz_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff  <= CLOCK_HZ_RESET;
         tempo_bpm_ff <= TEMPO_RESET;
      end else begin
         clock_hz_ff  <= clock_hz_in;
         tempo_bpm_ff <= tempo_bpm_in;
      end
   end

   mts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mts_datapath #(
      .NOTE_DEPTH (NOTE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .clock_hz   (clock_hz_ff),
      .tempo_bpm  (tempo_bpm_ff),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // A word is never taken while a stalled response still occupies the register.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!rsp_tvalid || rsp_tready))
      else $error("request taken while response register was blocked");

   // The end-of-melody tick always reports that a note ran.
   a_done_playing: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tdata[1])
      else $error("melody end reported without a playing note");

   // The buzzer only sounds while a note is running.
   a_level_playing: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> rsp_tdata[1])
      else $error("buzzer high while not playing");

   // An empty start stops playback in the very next response.
   a_empty_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == CMD_START) && (req_tdata[33:27] == 7'd0))
      |=> (rsp_tvalid && !rsp_tdata[1]))
      else $error("empty start did not stop playback");
`endif

endmodule

[verif/tb.sv]
// Self-checking bench for melody_tone_sequencer_core: a table of opening words, then
// melodies with random notes over several clock and tempo settings, each one
// checked against a player written in this file. Depends on mts_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import mts_pkg::*;

   localparam logic [REQ_USER_W-1:0] CMD_UNUSED = 2'd3;
   localparam int NOTE_SLOTS      = NOTE_DEPTH_DEFAULT;
   localparam int PHASES          = 9;
   localparam int WORDS_PER_PHASE = 110;
   localparam int SETTLE_CYCLES   = 200;
   localparam int DRAIN_CYCLES    = 150;
   localparam int CYCLE_LIMIT     = 3000000;
   localparam int SCRIPT_ROWS     = 17;
   localparam int MAX_REPORTS     = 30;

   typedef struct packed {
      logic [REQ_USER_W-1:0]    cmd;
      logic [SLOT_W-1:0]        slot;
      logic [FREQ_W-1:0]        freq;
      logic signed [CODE_W-1:0] code;
      logic [MLEN_W-1:0]        mlen;
   } player_word_t;

   typedef struct packed {
      logic             level;
      logic             playing;
      logic             done;
      logic [POS_W-1:0] pos;
   } buzzer_word_t;

   typedef struct packed {
      player_word_t word;
      logic         typed;
      buzzer_word_t want;
   } script_row_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   melody_tone_sequencer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Player state kept by the bench.
   logic [FREQ_W-1:0]        stored_freq [NOTE_SLOTS];
   logic signed [CODE_W-1:0] stored_code [NOTE_SLOTS];
   bit                       slot_loaded [NOTE_SLOTS];
   int unsigned              cfg_clock_hz  = CLOCK_HZ_RESET;
   int unsigned              cfg_tempo     = TEMPO_RESET;
   int unsigned              tune_len      = 0;
   int unsigned              sounding_idx  = 0;
   bit                       tune_running  = 1'b0;
   int unsigned              wave_period   = 0;
   int unsigned              wave_phase    = 0;
   logic [TICKS_W-1:0]       ticks_to_go   = '0;

   buzzer_word_t buzzer_words_due [$];
   buzzer_word_t seen_word;
   buzzer_word_t want_word;
   script_row_t  opening_script [SCRIPT_ROWS];
   int           words_sent     = 0;
   int           responses_seen = 0;
   int           mismatches     = 0;
   int           cycle_count    = 0;
   bit           req_bursty     = 1'b1;
   bit           rsp_bursty     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s: got %0d, expected %0d (response %0d)",
                  what, got, want, responses_seen);
   endtask

   // Sets up the note at idx: tone period from the frequency, length in ticks
   // from the tempo and the signed length code.
   function automatic void cue_note(int unsigned idx);
      int unsigned     f;
      int unsigned     mag;
      int unsigned     bpm;
      int unsigned     whole_ms;
      int unsigned     note_ms;
      int              code;
      longint unsigned span;
      f = stored_freq[idx];
      code = int'(stored_code[idx]);
      sounding_idx = idx;
      wave_phase = 0;
      wave_period = (f != 0) ? cfg_clock_hz / f : 0;
      mag = (code < 0) ? -code : code;
      if (mag == 0)
         mag = 1;
      bpm = (cfg_tempo == 0) ? 1 : cfg_tempo;
      whole_ms = (MS_PER_MIN / bpm) * 4;
      note_ms = whole_ms / mag;
      if (code < 0)
         note_ms = note_ms * 3 / 2;
      span = cfg_clock_hz / MS_PER_S;
      span = span * note_ms;
      if (span > 64'hFFFF_FFFF)
         span = 64'hFFFF_FFFF;
      if (span == 0)
         span = 1;
      ticks_to_go = span[TICKS_W-1:0];
   endfunction

   function automatic buzzer_word_t step_player(player_word_t w);
      buzzer_word_t r;
      int unsigned  n;
      r = '0;
      if (w.cmd == CMD_TICK) begin
         r.pos = POS_W'(sounding_idx);
         if (tune_running) begin
            r.playing = 1'b1;
            r.level = (wave_period >= 2 && wave_phase < wave_period / 2);
            wave_phase++;
            if (wave_phase >= wave_period)
               wave_phase = 0;
            ticks_to_go--;
            if (ticks_to_go == 0) begin
               if (sounding_idx + 1 < tune_len) begin
                  cue_note(sounding_idx + 1);
               end else begin
                  tune_running = 1'b0;
                  r.done = 1'b1;
               end
            end
         end
      end else begin
         if (w.cmd == CMD_LOAD) begin
            stored_freq[w.slot] = w.freq;
            stored_code[w.slot] = w.code;
         end else if (w.cmd == CMD_START) begin
            n = w.mlen;
            tune_len = (n > NOTE_SLOTS) ? NOTE_SLOTS : n;
            if (tune_len == 0) begin
               tune_running = 1'b0;
               sounding_idx = 0;
            end else begin
               tune_running = 1'b1;
               cue_note(0);
            end
         end
         r.playing = tune_running;
         r.pos = POS_W'(sounding_idx);
      end
      return r;
   endfunction

   function automatic int draw_gap(bit bursty);
      return bursty ? $urandom_range(0, 15) : 0;
   endfunction

   // Number of store entries written from slot 0 up without a hole; a start
   // asks for more notes than this only once the whole store is loaded.
   function automatic int loaded_prefix();
      int n;
      n = 0;
      while (n < NOTE_SLOTS && slot_loaded[n])
         n++;
      return n;
   endfunction

   // Zero, a random value, or a frequency that gives a short tone period at the
   // current clock, so the square wave toggles within a note.
   function automatic logic [FREQ_W-1:0] pick_freq();
      int unsigned sel;
      int unsigned target;
      sel = $urandom_range(0, 9);
      if (sel < 2)
         return '0;
      if (sel < 6) begin
         target = cfg_clock_hz / $urandom_range(2, 24);
         if (target == 0)
            target = 1;
         if (target > 8191)
            target = 8191;
         return FREQ_W'(target);
      end
      return FREQ_W'($urandom_range(0, 8191));
   endfunction

   function automatic logic signed [CODE_W-1:0] pick_code();
      int c;
      if ($urandom_range(0, 7) == 0)
         return CODE_W'($urandom_range(0, 255));
      c = $urandom_range(12, 64);
      if ($urandom_range(0, 1) == 1)
         c = -c;
      return CODE_W'(c);
   endfunction

   function automatic player_word_t random_word(logic [REQ_USER_W-1:0] cmd);
      player_word_t w;
      w.cmd = cmd;
      w.slot = SLOT_W'($urandom_range(0, NOTE_SLOTS - 1));
      w.freq = pick_freq();
      w.code = pick_code();
      w.mlen = MLEN_W'($urandom_range(0, 127));
      return w;
   endfunction

   // Called at a rising edge; returns at the edge where the word was taken,
   // with req_tvalid still high.
   task automatic send_word(input player_word_t w, input bit typed, input buzzer_word_t want);
      int           gap;
      buzzer_word_t predicted;
      gap = draw_gap(req_bursty);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= w.cmd;
      req_tdata <= REQ_DATA_W'({w.mlen, w.code, w.freq, w.slot});
      do @(posedge clock); while (!req_tready);
      predicted = step_player(w);
      buzzer_words_due.push_back(typed ? want : predicted);
      if (w.cmd == CMD_LOAD)
         slot_loaded[w.slot] = 1'b1;
      if (w.cmd != CMD_UNUSED)
         words_sent++;
      if ($urandom_range(0, 39) == 0)
         req_bursty = !req_bursty;
   endtask

   task automatic apply_settings(input int unsigned hz, input int unsigned bpm);
      req_tvalid <= 1'b0;
      while (buzzer_words_due.size() != 0)
         @(posedge clock);
      // A tick that ends a note leaves the divider busy after its response.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CLOCK_HZ;
      csr_wdata <= CSR_DATA_W'(hz);
      @(posedge clock);
      csr_index <= CSR_TEMPO_BPM;
      csr_wdata <= CSR_DATA_W'(bpm);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_clock_hz = hz;
      cfg_tempo = bpm;
   endtask

   // One melody: load its notes, start it, and tick it until it ends or tick_cap runs
   // out; unless fill_all, stray loads, unused commands, restarts and stops mix in.
   task automatic play_episode(input int tick_cap, input bit fill_all);
      player_word_t w;
      int           len;
      int           prefix;
      int           i;
      int           ticks;
      int           sel;
      prefix = loaded_prefix();
      len = fill_all ? NOTE_SLOTS : $urandom_range(1, 6);
      for (i = 0; i < len; i++) begin
         if (i >= prefix || $urandom_range(0, 1) == 1) begin
            w = random_word(CMD_LOAD);
            w.slot = SLOT_W'(i);
            send_word(w, 1'b0, '0);
         end
      end
      w = random_word(CMD_START);
      w.mlen = MLEN_W'(len);
      if (len == NOTE_SLOTS && $urandom_range(0, 1) == 1)
         w.mlen = MLEN_W'($urandom_range(NOTE_SLOTS + 1, 127));
      send_word(w, 1'b0, '0);
      ticks = 0;
      while (tune_running && ticks < tick_cap) begin
         sel = fill_all ? 0 : $urandom_range(0, 99);
         if (sel < 88) begin
            w = random_word(CMD_TICK);
            ticks++;
         end else if (sel < 93) begin
            w = random_word(CMD_LOAD);
         end else if (sel < 95) begin
            w = random_word(CMD_UNUSED);
         end else if (sel < 98) begin
            w = random_word(CMD_START);
            prefix = loaded_prefix();
            if (prefix == NOTE_SLOTS && $urandom_range(0, 1) == 1)
               w.mlen = MLEN_W'($urandom_range(NOTE_SLOTS + 1, 127));
            else
               w.mlen = MLEN_W'($urandom_range(1, prefix));
         end else begin
            w = random_word(CMD_START);
            w.mlen = '0;
         end
         send_word(w, 1'b0, '0);
      end
      repeat ($urandom_range(0, 2)) send_word(random_word(CMD_TICK), 1'b0, '0);
   endtask

   // Response side: random back-pressure, then compare each word with the
   // oldest one due.
   initial begin : rsp_side
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_gap(rsp_bursty);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if ($urandom_range(0, 39) == 0)
            rsp_bursty = !rsp_bursty;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_word.level = rsp_tdata[0];
         seen_word.playing = rsp_tdata[1];
         seen_word.pos = rsp_tdata[2 +: POS_W];
         seen_word.done = rsp_tlast;
         if (buzzer_words_due.size() == 0) begin
            report_mismatch("response word with nothing pending", 1, 0);
         end else begin
            want_word = buzzer_words_due.pop_front();
            if (seen_word.level !== want_word.level)
               report_mismatch("buzzer_level", seen_word.level, want_word.level);
            if (seen_word.playing !== want_word.playing)
               report_mismatch("playing", seen_word.playing, want_word.playing);
            if (seen_word.pos !== want_word.pos)
               report_mismatch("note_position", seen_word.pos, want_word.pos);
            if (seen_word.done !== want_word.done)
               report_mismatch("melody_done", seen_word.done, want_word.done);
         end
         responses_seen++;
      end
   end

   initial begin : req_side
      int unsigned phase_hz  [PHASES] = '{999, 1000, 1500, 0, 100000000, 1000,
                                          100000000, 5000, 1999};
      int unsigned phase_bpm [PHASES] = '{0, 1000, 600, 0, 30, 30, 0, 1000, 1000};
      int          phase_cap [PHASES] = '{100, 60, 60, 60, 12, 40, 12, 60, 60};
      int unsigned hz;
      int unsigned bpm;
      int          ph;
      int          row;
      int          phase_end;
      bit          first_episode;

      // Columns: cmd, slot, freq, code, mlen | typed | level, playing, done | pos.
      // Rows run at the reset clock and tempo, where every note is long.
      opening_script[ 0] = {CMD_TICK,   6'd0,  13'd0,    8'sd0,   7'd0, 1'b1, 3'b000, 6'd0};
      opening_script[ 1] = {CMD_UNUSED, 6'd0,  13'd0,    8'sd0,   7'd0, 1'b1, 3'b000, 6'd0};
      opening_script[ 2] = {CMD_START,  6'd0,  13'd0,    8'sd0,   7'd0, 1'b1, 3'b000, 6'd0};
      opening_script[ 3] = {CMD_LOAD,   6'd0,  13'd8191, 8'sd64,  7'd0, 1'b1, 3'b000, 6'd0};
      opening_script[ 4] = {CMD_LOAD,   6'd1,  13'd0,   -8'sd64,  7'd0, 1'b1, 3'b000, 6'd0};
      opening_script[ 5] = {CMD_LOAD,   6'd2,  13'd4000, 8'sd0,   7'd0, 1'b1, 3'b000, 6'd0};
      // The most negative code, a dotted note of 1/128.
      opening_script[ 6] = {CMD_LOAD,   6'd3,  13'd1,    8'sh80,  7'd0, 1'b1, 3'b000, 6'd0};
      opening_script[ 7] = {CMD_LOAD,   6'd63, 13'd8191, 8'sd127, 7'd0, 1'b1, 3'b000, 6'd0};
      opening_script[ 8] = {CMD_START,  6'd0,  13'd0,    8'sd0,   7'd4, 1'b1, 3'b010, 6'd0};
      opening_script[ 9] = {CMD_TICK,   6'd0,  13'd0,    8'sd0,   7'd0, 1'b0, 3'b000, 6'd0};
      opening_script[10] = {CMD_TICK,   6'd0,  13'd0,    8'sd0,   7'd0, 1'b0, 3'b000, 6'd0};
      opening_script[11] = {CMD_LOAD,   6'd1,  13'd200,  8'sd8,   7'd0, 1'b1, 3'b010, 6'd0};
      opening_script[12] = {CMD_UNUSED, 6'd0,  13'd0,    8'sd0,   7'd0, 1'b1, 3'b010, 6'd0};
      opening_script[13] = {CMD_START,  6'd0,  13'd0,    8'sd0,   7'd2, 1'b1, 3'b010, 6'd0};
      opening_script[14] = {CMD_TICK,   6'd0,  13'd0,    8'sd0,   7'd0, 1'b0, 3'b000, 6'd0};
      opening_script[15] = {CMD_START,  6'd0,  13'd0,    8'sd0,   7'd0, 1'b1, 3'b000, 6'd0};
      opening_script[16] = {CMD_TICK,   6'd0,  13'd0,    8'sd0,   7'd0, 1'b1, 3'b000, 6'd0};

      do @(posedge clock); while (reset);
      for (row = 0; row < SCRIPT_ROWS; row++)
         send_word(opening_script[row].word, opening_script[row].typed,
                   opening_script[row].want);

      // The first phase runs a clock below 1 kHz with tempo 0, so every note
      // rounds to zero ticks and lasts one; it also fills the whole store.
      for (ph = 0; ph < PHASES; ph++) begin
         hz = phase_hz[ph];
         bpm = phase_bpm[ph];
         if (hz == 0) begin
            hz = $urandom_range(1000, 4000);
            bpm = $urandom_range(400, 1000);
         end
         apply_settings(hz, bpm);
         phase_end = words_sent + WORDS_PER_PHASE;
         first_episode = (ph == 0);
         while (words_sent < phase_end) begin
            play_episode(phase_cap[ph], first_episode);
            first_episode = 1'b0;
         end
      end

      req_tvalid <= 1'b0;
      while (buzzer_words_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
